/* src/hsvrgb_pkg.sv */
package hsvrgb_pkg;

  // Default width of saturation, brightness and each colour channel.
  localparam int CHANNEL_BITS_DEF = 8;

  // Hue input width and the width of the distance from a pair's centre (0..60).
  localparam int HUE_BITS  = 9;
  localparam int DIST_BITS = 6;

  // Clock edges from the accepting edge to the edge that takes the result.
  localparam int PIPE_DEPTH = 6;

  // Hue boundaries, wide enough for the wrap of 360..511.
  localparam logic [9:0] DEG_60  = 10'd60;
  localparam logic [9:0] DEG_120 = 10'd120;
  localparam logic [9:0] DEG_180 = 10'd180;
  localparam logic [9:0] DEG_240 = 10'd240;
  localparam logic [9:0] DEG_300 = 10'd300;
  localparam logic [9:0] DEG_360 = 10'd360;

  // 60-degree sectors, named by the largest and then the middle channel.
  typedef enum logic [2:0] {
    SEC_RG = 3'd0,
    SEC_GR = 3'd1,
    SEC_GB = 3'd2,
    SEC_BG = 3'd3,
    SEC_BR = 3'd4,
    SEC_RB = 3'd5
  } sector_t;

  // Control that travels down the pipeline with each word.
  typedef struct packed {
    logic    vld;
    sector_t sector;
  } ctl_t;

endpackage

/* src/hsvrgb_hue.sv */
module hsvrgb_hue #(
  parameter int N = hsvrgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [hsvrgb_pkg::HUE_BITS-1:0]  hue,
  input  logic [N-1:0]                  sat,
  input  logic [N-1:0]                  val,
  output hsvrgb_pkg::ctl_t              ctl_o,
  output logic [hsvrgb_pkg::DIST_BITS-1:0] dist_o,
  output logic [N-1:0]                  sat_o,
  output logic [N-1:0]                  val_o
);
  import hsvrgb_pkg::*;

  logic [9:0]           h_red;
  logic [9:0]           base;
  logic [9:0]           off;
  logic [9:0]           dist_full;
  sector_t              sector_nxt;
  ctl_t                 ctl_r;
  logic [DIST_BITS-1:0] dist_r;
  logic [DIST_BITS-1:0] dist_nxt;
  logic [N-1:0]         sat_r;
  logic [N-1:0]         val_r;

  // Fold hues of 360 and above back into one turn.
  assign h_red = ({1'b0, hue} >= DEG_360) ? ({1'b0, hue} - DEG_360) : {1'b0, hue};

  // Find the sector and the start of its 120-degree pair.
  always_comb begin
    priority if (h_red < DEG_60) begin
      sector_nxt = SEC_RG;
      base       = '0;
    end else if (h_red < DEG_120) begin
      sector_nxt = SEC_GR;
      base       = '0;
    end else if (h_red < DEG_180) begin
      sector_nxt = SEC_GB;
      base       = DEG_120;
    end else if (h_red < DEG_240) begin
      sector_nxt = SEC_BG;
      base       = DEG_120;
    end else if (h_red < DEG_300) begin
      sector_nxt = SEC_BR;
      base       = DEG_240;
    end else begin
      sector_nxt = SEC_RB;
      base       = DEG_240;
    end
  end

  // Distance of the hue from the centre of its pair.
  assign off       = h_red - base;
  assign dist_full = (off >= DEG_60) ? (off - DEG_60) : (DEG_60 - off);
  assign dist_nxt  = dist_full[DIST_BITS-1:0];

  // Stage register: reset clears only the valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else begin
      ctl_r.vld <= in_vld;
    end
    ctl_r.sector <= sector_nxt;
    dist_r       <= dist_nxt;
    sat_r        <= sat;
    val_r        <= val;
  end

  assign ctl_o  = ctl_r;
  assign dist_o = dist_r;
  assign sat_o  = sat_r;
  assign val_o  = val_r;

endmodule

/* src/hsvrgb_mult.sv */
module hsvrgb_mult #(
  parameter int N = hsvrgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hsvrgb_pkg::ctl_t                 ctl_i,
  input  logic [hsvrgb_pkg::DIST_BITS-1:0] dist_i,
  input  logic [N-1:0]                     sat_i,
  input  logic [N-1:0]                     val_i,
  output hsvrgb_pkg::ctl_t                 ctl_o,
  output logic [2*N-1:0]                   lo_num_o,
  output logic [2*N+5:0]                   mid_num_o,
  output logic [N-1:0]                     val_o
);
  import hsvrgb_pkg::*;

  localparam int         SW     = N + DIST_BITS;
  localparam logic [N-1:0]  FS_V  = {N{1'b1}};
  localparam logic [SW-1:0] SPAN  = SW'(60 * ((1 << N) - 1));

  ctl_t          ctl2_r;
  ctl_t          ctl3_r;
  logic [SW-1:0] sd_r;
  logic [SW-1:0] sd_nxt;
  logic [2*N-1:0] lo2_r;
  logic [2*N-1:0] lo3_r;
  logic [2*N-1:0] lo_nxt;
  logic [N-1:0]  val2_r;
  logic [N-1:0]  val3_r;
  logic [SW-1:0] diff;
  logic [2*N+5:0] mid_r;
  logic [2*N+5:0] mid_nxt;

  // First products: saturation times distance, and the smallest channel numerator.
  assign sd_nxt = {{N{1'b0}}, dist_i} * {{DIST_BITS{1'b0}}, sat_i};
  assign lo_nxt = {{N{1'b0}}, val_i} * {{N{1'b0}}, FS_V - sat_i};

  // Second product: the middle channel numerator.
  assign diff    = SPAN - sd_r;
  assign mid_nxt = {{SW{1'b0}}, val2_r} * {{N{1'b0}}, diff};

  // Two stage registers: reset clears only the valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r.vld <= 1'b0;
      ctl3_r.vld <= 1'b0;
    end else begin
      ctl2_r.vld <= ctl_i.vld;
      ctl3_r.vld <= ctl2_r.vld;
    end
    ctl2_r.sector <= ctl_i.sector;
    ctl3_r.sector <= ctl2_r.sector;
    sd_r          <= sd_nxt;
    lo2_r         <= lo_nxt;
    lo3_r         <= lo2_r;
    val2_r        <= val_i;
    val3_r        <= val2_r;
    mid_r         <= mid_nxt;
  end

  assign ctl_o     = ctl3_r;
  assign lo_num_o  = lo3_r;
  assign mid_num_o = mid_r;
  assign val_o     = val3_r;

endmodule

/* src/hsvrgb_fsdiv.sv */
module hsvrgb_fsdiv #(
  parameter int N  = hsvrgb_pkg::CHANNEL_BITS_DEF,
  parameter int XW = 2 * hsvrgb_pkg::CHANNEL_BITS_DEF,
  parameter int QW = hsvrgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic [XW-1:0] x,
  output logic [QW-1:0] q
);
  localparam int             AW   = XW + 1;
  localparam int             QAW  = AW - N;
  localparam logic [AW-1:0]  FS_A = AW'((64'd1 << N) - 64'd1);

  logic [AW-1:0]  acc;
  logic [QAW-1:0] q0;
  logic [AW-1:0]  qfs;
  logic [AW-1:0]  rem;
  logic [QAW-1:0] q_full;

  // Divide by 2^N - 1 as x * (1 + 2^-N + 2^-2N) / 2^N, which never overshoots.
  assign acc = AW'(x) + AW'(x >> N) + AW'(x >> (2 * N));
  assign q0  = acc[AW-1:N];

  // The estimate is at most one low: correct it from the remainder.
  assign qfs    = {q0, {N{1'b0}}} - AW'(q0);
  assign rem    = AW'(x) - qfs;
  assign q_full = (rem >= FS_A) ? (q0 + QAW'(1)) : q0;
  assign q      = q_full[QW-1:0];

endmodule

/* src/hsvrgb_scale.sv */
module hsvrgb_scale #(
  parameter int N = hsvrgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  hsvrgb_pkg::ctl_t ctl_i,
  input  logic [2*N-1:0]   lo_num_i,
  input  logic [2*N+5:0]   mid_num_i,
  input  logic [N-1:0]     val_i,
  output hsvrgb_pkg::ctl_t ctl_o,
  output logic [N-1:0]     lo_o,
  output logic [N-1:0]     mid_o,
  output logic [N-1:0]     val_o
);
  import hsvrgb_pkg::*;

  // Division by 60 as a multiply by a rounded-up reciprocal, exact over the range.
  localparam int              YW   = N + DIST_BITS;
  localparam int              SH   = YW + 6;
  localparam int              KW   = SH - 5;
  localparam longint unsigned KVAL = ((64'd1 << SH) + 64'd59) / 64'd60;
  localparam logic [KW-1:0]   K_V  = KW'(KVAL);
  localparam int              PW   = YW + KW;

  ctl_t          ctl4_r;
  ctl_t          ctl5_r;
  logic [YW-1:0] mid_y;
  logic [YW-1:0] mid_y_r;
  logic [N-1:0]  lo_q;
  logic [N-1:0]  lo4_r;
  logic [N-1:0]  lo5_r;
  logic [N-1:0]  val4_r;
  logic [N-1:0]  val5_r;
  logic [PW-1:0] prod_r;
  logic [PW-1:0] prod_nxt;

  // Both numerators are first divided by full scale.
  hsvrgb_fsdiv #(.N(N), .XW(2 * N), .QW(N)) u_lo_div (
    .x (lo_num_i),
    .q (lo_q)
  );

  hsvrgb_fsdiv #(.N(N), .XW(2 * N + 6), .QW(YW)) u_mid_div (
    .x (mid_num_i),
    .q (mid_y)
  );

  // Then the middle channel is divided by 60.
  assign prod_nxt = {{KW{1'b0}}, mid_y_r} * {{YW{1'b0}}, K_V};

  // Two stage registers: reset clears only the valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r.vld <= 1'b0;
      ctl5_r.vld <= 1'b0;
    end else begin
      ctl4_r.vld <= ctl_i.vld;
      ctl5_r.vld <= ctl4_r.vld;
    end
    ctl4_r.sector <= ctl_i.sector;
    ctl5_r.sector <= ctl4_r.sector;
    mid_y_r       <= mid_y;
    lo4_r         <= lo_q;
    lo5_r         <= lo4_r;
    val4_r        <= val_i;
    val5_r        <= val4_r;
    prod_r        <= prod_nxt;
  end

  assign ctl_o = ctl5_r;
  assign lo_o  = lo5_r;
  assign mid_o = prod_r[SH +: N];
  assign val_o = val5_r;

endmodule

/* src/hsv_to_rgb_pixel_top.sv */
// HSV to RGB pixel converter.
// Input channel: a word of in_hue (whole degrees, 0..359; 360..511 wrap to
// 0..151), in_saturation and in_brightness (full scale means 1.0) is taken at
// each rising edge where start is high and busy is low. busy is always low,
// so a new pixel may be offered in every clock cycle.
// Result channel: out_red, out_green and out_blue are shown for exactly one
// cycle with out_valid high; the receiver takes them at the edge ending that
// cycle and cannot hold them off, so nothing in the pipeline ever waits.
// The pipeline has six register stages: hue decode, two multiply stages,
// the division by full scale, the reciprocal multiply for the division by
// 60, and the output register.
// Throughput: one pixel per clock, set by the fully pipelined multipliers.
// Reset (rst_n low, synchronous) clears the valid bits of every stage, so
// no result appears for a word that was in flight; the data registers are
// not cleared.
module hsv_to_rgb_pixel_top #(
  parameter int CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [hsvrgb_pkg::HUE_BITS-1:0] in_hue,
  input  logic [CHANNEL_BITS-1:0]         in_saturation,
  input  logic [CHANNEL_BITS-1:0]         in_brightness,
  output logic                            out_valid,
  output logic [CHANNEL_BITS-1:0]         out_red,
  output logic [CHANNEL_BITS-1:0]         out_green,
  output logic [CHANNEL_BITS-1:0]         out_blue
);
  import hsvrgb_pkg::*;

  localparam int N = CHANNEL_BITS;

  ctl_t                 ctl1;
  ctl_t                 ctl3;
  ctl_t                 ctl5;
  logic [DIST_BITS-1:0] dist1;
  logic [N-1:0]         sat1;
  logic [N-1:0]         val1;
  logic [2*N-1:0]       lo_num3;
  logic [2*N+5:0]       mid_num3;
  logic [N-1:0]         val3;
  logic [N-1:0]         lo5;
  logic [N-1:0]         mid5;
  logic [N-1:0]         val5;
  logic                 valid_r;
  logic [N-1:0]         red_r;
  logic [N-1:0]         red_nxt;
  logic [N-1:0]         green_r;
  logic [N-1:0]         green_nxt;
  logic [N-1:0]         blue_r;
  logic [N-1:0]         blue_nxt;

  // The pipeline never stalls.
  assign busy = 1'b0;

  hsvrgb_hue #(.N(N)) u_hue (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start & ~busy),
    .hue    (in_hue),
    .sat    (in_saturation),
    .val    (in_brightness),
    .ctl_o  (ctl1),
    .dist_o (dist1),
    .sat_o  (sat1),
    .val_o  (val1)
  );

  hsvrgb_mult #(.N(N)) u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl1),
    .dist_i    (dist1),
    .sat_i     (sat1),
    .val_i     (val1),
    .ctl_o     (ctl3),
    .lo_num_o  (lo_num3),
    .mid_num_o (mid_num3),
    .val_o     (val3)
  );

  hsvrgb_scale #(.N(N)) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl3),
    .lo_num_i  (lo_num3),
    .mid_num_i (mid_num3),
    .val_i     (val3),
    .ctl_o     (ctl5),
    .lo_o      (lo5),
    .mid_o     (mid5),
    .val_o     (val5)
  );

  // Place the largest, middle and smallest values by sector.
  always_comb begin
    unique case (ctl5.sector)
      SEC_RG: begin
        red_nxt = val5;  green_nxt = mid5; blue_nxt = lo5;
      end
      SEC_GR: begin
        red_nxt = mid5;  green_nxt = val5; blue_nxt = lo5;
      end
      SEC_GB: begin
        red_nxt = lo5;   green_nxt = val5; blue_nxt = mid5;
      end
      SEC_BG: begin
        red_nxt = lo5;   green_nxt = mid5; blue_nxt = val5;
      end
      SEC_BR: begin
        red_nxt = mid5;  green_nxt = lo5;  blue_nxt = val5;
      end
      SEC_RB: begin
        red_nxt = val5;  green_nxt = lo5;  blue_nxt = mid5;
      end
      default: begin
        red_nxt = val5;  green_nxt = lo5;  blue_nxt = mid5;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl5.vld;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign out_valid = valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // Every result comes from an accepted word.
  a_result_from_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, PIPE_DEPTH))
    else $error("result without an accepted word");

  // One channel always carries the brightness of that word.
  a_largest_is_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red == $past(in_brightness, PIPE_DEPTH)) ||
                  (out_green == $past(in_brightness, PIPE_DEPTH)) ||
                  (out_blue == $past(in_brightness, PIPE_DEPTH)))
    else $error("no channel equals the brightness");

  // No channel exceeds the brightness.
  a_channels_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red <= $past(in_brightness, PIPE_DEPTH)) &&
                  (out_green <= $past(in_brightness, PIPE_DEPTH)) &&
                  (out_blue <= $past(in_brightness, PIPE_DEPTH)))
    else $error("channel above the brightness");

  // Zero saturation gives grey.
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_saturation, PIPE_DEPTH) == '0)) |->
      (out_red == out_green) && (out_green == out_blue))
    else $error("unsaturated pixel is not grey");

endmodule
